@@ rtl/core/traffic_phase_selector_assert.svh @@
// assertion macros for the traffic phase selector
// used by the top level only, no other dependencies
`ifndef TRAFFIC_PHASE_SELECTOR_ASSERT_SVH
`define TRAFFIC_PHASE_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TPS_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TPS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/core/tps_pkg.sv @@
// shared types and constants for the traffic phase selector
// no dependencies
`default_nettype none

package tps_pkg;

   localparam int NUM_CARS   = 4;
   localparam int NUM_PEDS   = 8;
   localparam int QUEUE_W    = 8;
   localparam int CAR_IDX_W  = 2;
   localparam int PED_IDX_W  = 3;
   localparam int PHASE_W    = 3;
   localparam int COUNT_W    = 4;
   localparam int LIMIT_W    = 8;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic [LIMIT_W-1:0] CAR_IDLE_RESET = 8'd3;
   localparam logic [LIMIT_W-1:0] PED_LOW_RESET  = 8'd4;
   localparam logic [COUNT_W-1:0] PERIOD_RESET   = 4'd2;

   typedef logic [QUEUE_W-1:0] queue_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_AXIS_EVEN = 3'd0,
      PHASE_AXIS_ODD  = 3'd1,
      PHASE_CAR0_PED  = 3'd2,
      PHASE_CAR1_PED  = 3'd3,
      PHASE_CAR2_PED  = 3'd4,
      PHASE_CAR3_PED  = 3'd5,
      PHASE_ALL_PED   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      REG_CAR_IDLE = 2'd0,
      REG_PED_LOW  = 2'd1,
      REG_PERIOD   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] car_idle_limit;
      logic [LIMIT_W-1:0] ped_low_limit;
      logic [COUNT_W-1:0] override_period;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic      forced;
   } decision_type;

endpackage

`default_nettype wire

@@ rtl/core/tps_decide.sv @@
// phase decision logic: longest queues, threshold rules, override
// depends on tps_pkg
`default_nettype none

module tps_decide (
   input  tps_pkg::queue_type                       car_queue [tps_pkg::NUM_CARS],
   input  tps_pkg::queue_type                       ped_queue [tps_pkg::NUM_PEDS],
   input  tps_pkg::cfg_type                         cfg,
   input  logic [tps_pkg::COUNT_W-1:0]              decision_count,
   output tps_pkg::decision_type                    decision
);
   import tps_pkg::*;

   queue_type            car_max;
   logic [CAR_IDX_W-1:0] car_idx;
   queue_type            ped_max;
   logic [PED_IDX_W-1:0] ped_idx;
   phase_type            rule_phase;
   phase_type            axis_phase;
   logic                 force_axis;

   // strict compare keeps the lowest index on a tie
   always_comb begin
      car_max = '0;
      car_idx = '0;
      for (int i = 0; i < NUM_CARS; i++) begin
         if (car_queue[i] > car_max) begin
            car_max = car_queue[i];
            car_idx = CAR_IDX_W'(i);
         end
      end
   end

   always_comb begin
      ped_max = '0;
      ped_idx = '0;
      for (int i = 0; i < NUM_PEDS; i++) begin
         if (ped_queue[i] > ped_max) begin
            ped_max = ped_queue[i];
            ped_idx = PED_IDX_W'(i);
         end
      end
   end

   assign axis_phase = car_idx[0] ? PHASE_AXIS_ODD : PHASE_AXIS_EVEN;

   always_comb begin
      rule_phase = PHASE_ALL_PED;
      if (car_max <= cfg.car_idle_limit) begin
         rule_phase = PHASE_ALL_PED;
      end else if (ped_max <= cfg.ped_low_limit) begin
         rule_phase = axis_phase;
      end else begin
         // each approach pairs with two crossings
         case (car_idx)
            2'd0: begin
               if (ped_idx == 3'd1 || ped_idx == 3'd4) rule_phase = PHASE_CAR0_PED;
            end
            2'd1: begin
               if (ped_idx == 3'd3 || ped_idx == 3'd6) rule_phase = PHASE_CAR1_PED;
            end
            2'd2: begin
               if (ped_idx == 3'd5 || ped_idx == 3'd0) rule_phase = PHASE_CAR2_PED;
            end
            2'd3: begin
               if (ped_idx == 3'd7 || ped_idx == 3'd2) rule_phase = PHASE_CAR3_PED;
            end
            default: rule_phase = PHASE_ALL_PED;
         endcase
      end
   end

   assign force_axis      = (decision_count >= cfg.override_period);
   assign decision.phase  = force_axis ? axis_phase : rule_phase;
   assign decision.forced = force_axis;

endmodule

`default_nettype wire

@@ rtl/core/traffic_phase_selector.sv @@
// top level of the traffic phase selector: input register, decision, result register,
// configuration registers; depends on tps_pkg, tps_decide and the assertion header
`default_nettype none

// Takes one decision request per cycle while req_stall is low and returns one phase word
// per request, offered on the result port: the queues are captured in an input
// register, decided in a single pass through the compare logic, and held in a result
// register. A full throughput of one word per cycle holds while rsp_stall is low; under
// stall the input register keeps accepting until both stages are full. The override
// counter advances once per word as it enters the result register. Registers:
// car_idle_limit at 0x0, ped_low_limit at 0x4, override_period at 0x8; write them only
// while no word is in flight.
module traffic_phase_selector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_car_queue_0,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_car_queue_1,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_car_queue_2,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_car_queue_3,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_0,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_1,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_2,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_3,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_4,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_5,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_6,
   input  logic [tps_pkg::QUEUE_W-1:0]   req_ped_queue_7,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tps_pkg::PHASE_W-1:0]   rsp_phase,
   output logic                          rsp_forced,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tps_pkg::ADDR_W-1:0]    paddr,
   input  logic [tps_pkg::DATA_W-1:0]    pwdata,
   output logic [tps_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import tps_pkg::*;

   `include "traffic_phase_selector_assert.svh"

   logic                 in_valid_ff,  in_valid_in;
   queue_type            car_ff [NUM_CARS];
   queue_type            ped_ff [NUM_PEDS];
   logic                 out_valid_ff, out_valid_in;
   decision_type         out_ff;
   logic [COUNT_W-1:0]   count_ff,     count_in;
   cfg_type              cfg_ff,       cfg_in;

   decision_type         decision;
   logic                 out_advance;
   logic                 in_advance;
   logic                 req_take;
   logic                 cfg_write;
   reg_index_type        reg_index;

   assign out_advance = !out_valid_ff || !rsp_stall;
   assign in_advance  = in_valid_ff && out_advance;
   assign req_stall   = in_valid_ff && !out_advance;
   assign req_take    = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_advance);
   assign out_valid_in = in_advance || (out_valid_ff && rsp_stall);

   tps_decide u_decide (
      .car_queue      (car_ff),
      .ped_queue      (ped_ff),
      .cfg            (cfg_ff),
      .decision_count (count_ff),
      .decision       (decision)
   );

   // override restarts the count, then every word bumps it
   always_comb begin
      count_in = count_ff;
      if (in_advance) begin
         count_in = (decision.forced ? '0 : count_ff) + COUNT_W'(1);
      end
   end

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_CAR_IDLE: cfg_in.car_idle_limit  = pwdata[LIMIT_W-1:0];
            REG_PED_LOW:  cfg_in.ped_low_limit   = pwdata[LIMIT_W-1:0];
            REG_PERIOD:   cfg_in.override_period = pwdata[COUNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CAR_IDLE: prdata = DATA_W'(cfg_ff.car_idle_limit);
         REG_PED_LOW:  prdata = DATA_W'(cfg_ff.ped_low_limit);
         REG_PERIOD:   prdata = DATA_W'(cfg_ff.override_period);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         cfg_ff       <= '{car_idle_limit:  CAR_IDLE_RESET,
                           ped_low_limit:   PED_LOW_RESET,
                           override_period: PERIOD_RESET};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         car_ff[0] <= req_car_queue_0;
         car_ff[1] <= req_car_queue_1;
         car_ff[2] <= req_car_queue_2;
         car_ff[3] <= req_car_queue_3;
         ped_ff[0] <= req_ped_queue_0;
         ped_ff[1] <= req_ped_queue_1;
         ped_ff[2] <= req_ped_queue_2;
         ped_ff[3] <= req_ped_queue_3;
         ped_ff[4] <= req_ped_queue_4;
         ped_ff[5] <= req_ped_queue_5;
         ped_ff[6] <= req_ped_queue_6;
         ped_ff[7] <= req_ped_queue_7;
      end
      if (in_advance) begin
         out_ff <= decision;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_phase  = out_ff.phase;
   assign rsp_forced = out_ff.forced;

   `TPS_ASSERT_IMP(a_forced_axis, clock, reset, rsp_valid && rsp_forced,
      rsp_phase == PHASE_AXIS_EVEN || rsp_phase == PHASE_AXIS_ODD,
      "forced word carries a non-axis phase")
   `TPS_ASSERT_NEXT(a_override_taken, clock, reset,
      in_advance && count_ff >= cfg_ff.override_period,
      rsp_valid && rsp_forced, "override due but word not forced")
   `TPS_ASSERT_NEXT(a_count_restart, clock, reset, in_advance && decision.forced,
      count_ff == COUNT_W'(1), "count not restarted after override")

endmodule

`default_nettype wire

@@ sim/traffic_phase_selector_tb.sv @@
// testbench for traffic_phase_selector: random and directed decision requests,
// self-checking against a local phase predictor; depends on tps_pkg and the rtl top
`timescale 1ns / 100ps

module traffic_phase_selector_tb;
   import tps_pkg::*;

   typedef struct packed {
      logic [NUM_CARS-1:0][QUEUE_W-1:0] car;
      logic [NUM_PEDS-1:0][QUEUE_W-1:0] ped;
   } request_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_LIGHT,
      RX_HEAVY,
      RX_HOLD
   } rx_mode_type;

   localparam logic [ADDR_W-1:0] ADDR_CAR_IDLE = {REG_CAR_IDLE, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_PED_LOW  = {REG_PED_LOW, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_PERIOD   = {REG_PERIOD, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_SPARE    = 4'hC;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLD_CYCLES    = 250;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASE_ITEMS    = 150;
   localparam int NUM_PHASES     = 6;
   localparam int REPORT_LIMIT   = 10;

   logic clock;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   request_type         driven_request = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PHASE_W-1:0]  rsp_phase;
   logic                rsp_forced;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // local copy of the block's registers and override counter
   cfg_type             limits;
   logic [COUNT_W-1:0]  decisions_since_override;

   request_type         pending_requests[$];
   decision_type        expected_decisions[$];

   rx_mode_type         rx_mode = RX_LIGHT;
   rx_mode_type         prev_rx_mode = RX_LIGHT;
   logic                tx_dense = 1'b0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  hold_left = 0;
   int                  cycle_count = 0;
   int                  err_count = 0;
   int                  words_checked = 0;
   int                  forced_seen = 0;
   int                  csr_writes = 0;

   traffic_phase_selector u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_car_queue_0 (driven_request.car[0]),
      .req_car_queue_1 (driven_request.car[1]),
      .req_car_queue_2 (driven_request.car[2]),
      .req_car_queue_3 (driven_request.car[3]),
      .req_ped_queue_0 (driven_request.ped[0]),
      .req_ped_queue_1 (driven_request.ped[1]),
      .req_ped_queue_2 (driven_request.ped[2]),
      .req_ped_queue_3 (driven_request.ped[3]),
      .req_ped_queue_4 (driven_request.ped[4]),
      .req_ped_queue_5 (driven_request.ped[5]),
      .req_ped_queue_6 (driven_request.ped[6]),
      .req_ped_queue_7 (driven_request.ped[7]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_phase       (rsp_phase),
      .rsp_forced      (rsp_forced),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // longest queues, threshold rules, then the starvation override
   function automatic decision_type predict_decision(request_type r);
      queue_type            cmax;
      queue_type            pmax;
      logic [CAR_IDX_W-1:0] ci;
      logic [PED_IDX_W-1:0] pi;
      decision_type         d;
      cmax = '0;
      pmax = '0;
      ci = '0;
      pi = '0;
      for (int i = 0; i < NUM_CARS; i++) begin
         if (r.car[i] > cmax) begin
            cmax = r.car[i];
            ci = CAR_IDX_W'(i);
         end
      end
      for (int i = 0; i < NUM_PEDS; i++) begin
         if (r.ped[i] > pmax) begin
            pmax = r.ped[i];
            pi = PED_IDX_W'(i);
         end
      end
      d.forced = 1'b0;
      if (cmax <= limits.car_idle_limit)
         d.phase = PHASE_ALL_PED;
      else if (pmax <= limits.ped_low_limit)
         d.phase = ci[0] ? PHASE_AXIS_ODD : PHASE_AXIS_EVEN;
      else if (ci == 0 && (pi == 1 || pi == 4))
         d.phase = PHASE_CAR0_PED;
      else if (ci == 1 && (pi == 3 || pi == 6))
         d.phase = PHASE_CAR1_PED;
      else if (ci == 2 && (pi == 5 || pi == 0))
         d.phase = PHASE_CAR2_PED;
      else if (ci == 3 && (pi == 7 || pi == 2))
         d.phase = PHASE_CAR3_PED;
      else
         d.phase = PHASE_ALL_PED;
      if (decisions_since_override >= limits.override_period) begin
         d.phase = ci[0] ? PHASE_AXIS_ODD : PHASE_AXIS_EVEN;
         d.forced = 1'b1;
         decisions_since_override = '0;
      end
      decisions_since_override = decisions_since_override + 1'b1;
      return d;
   endfunction

   // values cluster at zero, full scale and around the threshold
   function automatic queue_type pick_value(queue_type limit);
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 255;
         2, 3: v = int'(limit) + int'($urandom_range(0, 2)) - 1;
         4, 5: v = int'($urandom_range(0, 15));
         default: v = int'($urandom_range(0, 255));
      endcase
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return queue_type'(v);
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          a;
      int          b;
      for (int i = 0; i < NUM_CARS; i++)
         r.car[i] = pick_value(limits.car_idle_limit);
      for (int i = 0; i < NUM_PEDS; i++)
         r.ped[i] = pick_value(limits.ped_low_limit);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            // quiet crossings so the pure car-axis phases come up
            for (int i = 0; i < NUM_PEDS; i++)
               r.ped[i] = queue_type'($urandom_range(0, limits.ped_low_limit));
         end
         3: begin
            for (int i = 0; i < NUM_CARS; i++)
               r.car[i] = queue_type'($urandom_range(0, limits.car_idle_limit));
         end
         4: begin
            // force ties between two queues
            a = $urandom_range(0, NUM_CARS - 1);
            b = $urandom_range(0, NUM_CARS - 1);
            r.car[b] = r.car[a];
            a = $urandom_range(0, NUM_PEDS - 1);
            b = $urandom_range(0, NUM_PEDS - 1);
            r.ped[b] = r.ped[a];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic request_type spot_request(int car_at, queue_type car_val,
                                                int ped_at, queue_type ped_val);
      request_type r;
      r = '0;
      r.car[car_at] = car_val;
      r.ped[ped_at] = ped_val;
      return r;
   endfunction

   task automatic write_csr(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_CAR_IDLE)
         limits.car_idle_limit = data[LIMIT_W-1:0];
      else if (addr == ADDR_PED_LOW)
         limits.ped_low_limit = data[LIMIT_W-1:0];
      else if (addr == ADDR_PERIOD)
         limits.override_period = data[COUNT_W-1:0];
      csr_writes++;
   endtask

   // upper bits carry noise, the block keeps only the field width
   task automatic set_limits(logic [LIMIT_W-1:0] car_idle, logic [LIMIT_W-1:0] ped_low,
                             logic [COUNT_W-1:0] period);
      logic [DATA_W-1:0] noise;
      noise = $urandom;
      write_csr(ADDR_CAR_IDLE, {noise[DATA_W-1:LIMIT_W], car_idle});
      noise = $urandom;
      write_csr(ADDR_PED_LOW, {noise[DATA_W-1:LIMIT_W], ped_low});
      noise = $urandom;
      write_csr(ADDR_PERIOD, {noise[DATA_W-1:COUNT_W], period});
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_decisions.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // sender: bursts of random length, gaps between them unless dense
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_decisions.push_back(predict_decision(driven_request));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               driven_request <= pending_requests.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= tx_dense ? 0 : $urandom_range(0, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern per mode, one long hold when hold mode starts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         prev_rx_mode <= RX_LIGHT;
      end else begin
         prev_rx_mode <= rx_mode;
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (rx_mode == RX_HOLD && prev_rx_mode != RX_HOLD) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
         end else begin
            case (rx_mode)
               RX_FREE:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
               default:  rsp_stall <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      decision_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_decisions.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
               $display("unexpected word: phase %0d forced %0d", rsp_phase, rsp_forced);
         end else begin
            want = expected_decisions.pop_front();
            words_checked++;
            if (want.forced)
               forced_seen++;
            if (rsp_phase !== want.phase || rsp_forced !== want.forced) begin
               err_count++;
               if (err_count <= REPORT_LIMIT)
                  $display("word %0d mismatch: phase %0d forced %0d, expected %0d %0d",
                           words_checked, rsp_phase, rsp_forced, want.phase, want.forced);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("traffic_phase_selector_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      request_type        r;
      logic [LIMIT_W-1:0] car_idle;
      logic [LIMIT_W-1:0] ped_low;
      logic [COUNT_W-1:0] period;
      rx_mode_type        mode;
      logic               dense;

      limits.car_idle_limit = CAR_IDLE_RESET;
      limits.ped_low_limit = PED_LOW_RESET;
      limits.override_period = PERIOD_RESET;
      decisions_since_override = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: long period so the threshold rules show through
      set_limits(8'd3, 8'd4, 4'd15);
      pending_requests.push_back('0);
      pending_requests.push_back('1);
      r = '0;
      for (int i = 0; i < NUM_CARS; i++)
         r.car[i] = 8'd9;
      pending_requests.push_back(r);
      pending_requests.push_back(spot_request(1, 20, 0, 0));
      pending_requests.push_back(spot_request(3, 20, 0, 0));
      pending_requests.push_back(spot_request(2, 20, 0, 0));
      pending_requests.push_back(spot_request(0, 20, 1, 50));
      pending_requests.push_back(spot_request(0, 20, 4, 50));
      pending_requests.push_back(spot_request(1, 20, 3, 50));
      pending_requests.push_back(spot_request(1, 20, 6, 50));
      pending_requests.push_back(spot_request(2, 20, 5, 50));
      pending_requests.push_back(spot_request(2, 20, 0, 50));
      pending_requests.push_back(spot_request(3, 20, 7, 50));
      pending_requests.push_back(spot_request(3, 20, 2, 50));
      pending_requests.push_back(spot_request(0, 20, 2, 50));
      // car queue exactly at idle limit, pedestrians at and just above low limit
      pending_requests.push_back(spot_request(0, 3, 1, 50));
      pending_requests.push_back(spot_request(0, 4, 1, 4));
      pending_requests.push_back(spot_request(0, 4, 1, 5));
      // pedestrian tie resolves to the lower crossing
      r = '0;
      r.car[1] = 8'd30;
      r.ped[2] = 8'd40;
      r.ped[3] = 8'd40;
      pending_requests.push_back(r);
      wait_drained();

      // period lowered under the running count, then idle override
      write_csr(ADDR_PERIOD, 32'd1);
      pending_requests.push_back(spot_request(3, 200, 7, 200));
      pending_requests.push_back('0);
      wait_drained();

      // zero period forces every decision
      write_csr(ADDR_PERIOD, 32'd0);
      pending_requests.push_back(spot_request(1, 9, 0, 0));
      pending_requests.push_back(spot_request(2, 9, 5, 99));
      wait_drained();

      // write to an unmapped index must not touch the period
      write_csr(ADDR_PERIOD, 32'd7);
      write_csr(ADDR_SPARE, 32'd0);
      pending_requests.push_back(spot_request(2, 9, 5, 99));
      pending_requests.push_back(spot_request(3, 60, 2, 80));
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         car_idle = LIMIT_W'($urandom_range(0, 40));
         ped_low = LIMIT_W'($urandom_range(0, 40));
         period = COUNT_W'($urandom_range(1, 15));
         mode = RX_LIGHT;
         dense = 1'b0;
         case (ph)
            0: begin
               car_idle = CAR_IDLE_RESET;
               ped_low = PED_LOW_RESET;
               period = PERIOD_RESET;
            end
            1: begin
               car_idle = '0;
               ped_low = '0;
               period = 4'd1;
               mode = RX_FREE;
               dense = 1'b1;
            end
            2: begin
               car_idle = '1;
               ped_low = '1;
               period = '1;
               mode = RX_HEAVY;
            end
            3: begin
               mode = RX_HOLD;
               dense = 1'b1;
            end
            5: mode = RX_HEAVY;
            default: ;
         endcase
         set_limits(car_idle, ped_low, period);
         rx_mode <= mode;
         tx_dense <= dense;
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_requests.push_back(random_request());
         wait_drained();
      end

      if (expected_decisions.size() != 0)
         err_count++;
      $display("run covered %0d decision words (%0d by override) over %0d register writes",
               words_checked, forced_seen, csr_writes);
      if (err_count == 0)
         $display("traffic_phase_selector_tb: clean");
      else
         $display("traffic_phase_selector_tb: errors");
      $finish;
   end

endmodule
